>>> hdl/lfuc_pkg.sv
// Package for the LFU cache: sizes, widths, command codes and the
// controller/datapath command and status structs. No dependencies.
package lfuc_pkg;
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic load;     // latch request word, run key match
        logic update;   // apply the access to the entry state
    } t_dp_cmd;

    typedef struct packed {
        logic found;
        logic is_put;
        logic enabled;
    } t_dp_status;
endpackage

>>> hdl/lfuc_if.sv
// Valid/ready channel with a generic payload type.
// Depends on nothing.
interface lfuc_if #(parameter type t_payload = logic) (input logic i_clk);
    logic     valid;
    logic     ready;
    t_payload payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/lfuc_ctrl.sv
// Controller: sequences load, search and update of one word at a time,
// then holds the result until taken. Depends on lfuc_pkg.
module lfuc_ctrl import lfuc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_DONE} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.update = (r_state == S_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_SEARCH;
                S_SEARCH: r_state <= S_UPDATE;
                S_UPDATE: r_state <= S_DONE;
                S_DONE:   if (i_out_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.update)) else $error("load and update together");
    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> o_out_valid) else $error("update not followed by result");
    a_load_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> ##1 o_cmd.update) else $error("load not followed by update");
endmodule

>>> hdl/lfuc_dp.sv
// Datapath: entry registers, key match, victim search and state update.
// Depends on lfuc_pkg.
module lfuc_dp import lfuc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_capacity,
    input  t_dp_cmd           i_cmd,
    input  logic              i_in_cmd,
    input  logic [KEY_W-1:0]  i_in_key,
    input  logic [VAL_W-1:0]  i_in_value,
    output t_dp_status        o_status,
    output logic              o_hit,
    output logic [VAL_W-1:0]  o_read_value,
    output logic              o_evicted,
    output logic [KEY_W-1:0]  o_evicted_key
);
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0] r_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] r_data  [MAX_ENTRIES];
    logic [CNT_W-1:0] r_count [MAX_ENTRIES];
    logic [IDX_W-1:0] r_rank  [MAX_ENTRIES];
    logic [OCC_W-1:0] r_occ;
    logic [CAP_W-1:0] r_cap;

    logic             r_cmd;
    logic [KEY_W-1:0] r_req_key;
    logic [VAL_W-1:0] r_req_val;
    logic [MAX_ENTRIES-1:0] r_match;
    logic [MAX_ENTRIES-1:0] r_victim;  // one-hot LFU/LRU victim
    logic [MAX_ENTRIES-1:0] r_free;    // one-hot lowest free slot
    logic r_any_free;

    // effective capacity clamp
    logic [OCC_W-1:0] w_cap;
    assign w_cap = (r_cap > CAP_W'(MAX_ENTRIES)) ? OCC_W'(MAX_ENTRIES) : OCC_W'(r_cap);

    // match, free and victim search are registered after load
    logic [MAX_ENTRIES-1:0] n_match, n_free, n_victim;
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_match[i] = r_valid[i] && (r_key[i] == i_in_key);
        end
        n_free = ~r_valid & (r_valid + 1'b1);
        // entry i is the victim if it beats every other valid entry
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_victim[i] = r_valid[i];
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                if (j != i && r_valid[j] && ((r_count[j] < r_count[i]) ||
                    (r_count[j] == r_count[i] && r_rank[j] > r_rank[i])))
                    n_victim[i] = 1'b0;
            end
        end
    end

    logic w_found;
    assign w_found = |r_match;
    assign o_status.found   = w_found;
    assign o_status.is_put  = (r_cmd == CMD_PUT);
    assign o_status.enabled = (w_cap != '0);

    logic [IDX_W-1:0] w_hit_idx;
    logic [IDX_W-1:0] w_hit_rank;
    logic [IDX_W-1:0] w_vic_rank;
    logic [VAL_W-1:0] w_hit_data;
    logic [KEY_W-1:0] w_vic_key;
    always_comb begin
        w_hit_idx = '0; w_hit_rank = '0; w_vic_rank = '0;
        w_hit_data = '0; w_vic_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_match[i]) begin
                w_hit_idx  = IDX_W'(i);
                w_hit_rank = r_rank[i];
                w_hit_data = r_data[i];
            end
            if (r_victim[i]) begin
                w_vic_rank = r_rank[i];
                w_vic_key  = r_key[i];
            end
        end
    end

    logic w_en, w_do_hit, w_do_ins, w_do_evict;
    assign w_en       = (w_cap != '0);
    assign w_do_hit   = w_en && w_found;
    assign w_do_ins   = w_en && !w_found && (r_cmd == CMD_PUT);
    assign w_do_evict = w_do_ins && ((r_occ >= w_cap) || !r_any_free) && (|r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_W'(MAX_ENTRIES);
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_capacity;
            if (i_cmd.load) begin
                r_cmd     <= i_in_cmd;
                r_req_key <= i_in_key;
                r_req_val <= i_in_value;
                r_match   <= n_match;
                r_free    <= n_free;
                r_any_free <= ~&r_valid;
                r_victim  <= n_victim;
            end
            if (i_cmd.update) begin
                o_hit         <= w_do_hit;
                o_read_value  <= (w_do_hit && r_cmd == CMD_GET) ? w_hit_data : '1;
                o_evicted     <= w_do_evict;
                o_evicted_key <= w_do_evict ? w_vic_key : '0;
                if (w_do_hit) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (r_valid[i] && !r_match[i] && r_rank[i] < w_hit_rank)
                            r_rank[i] <= r_rank[i] + 1'b1;
                    end
                    r_rank[w_hit_idx] <= '0;
                    if (r_count[w_hit_idx] != '1)
                        r_count[w_hit_idx] <= r_count[w_hit_idx] + 1'b1;
                    if (r_cmd == CMD_PUT) r_data[w_hit_idx] <= r_req_val;
                end else if (w_do_ins && (w_do_evict || r_any_free)) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (w_do_evict ? r_victim[i] : r_free[i]) begin
                            r_valid[i] <= 1'b1;
                            r_key[i]   <= r_req_key;
                            r_data[i]  <= r_req_val;
                            r_count[i] <= CNT_W'(1);
                            r_rank[i]  <= '0;
                        end else if (r_valid[i]) begin
                            // removal shifts older ranks down, insert shifts all up
                            if (!(w_do_evict && r_rank[i] > w_vic_rank))
                                r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    if (!w_do_evict) r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    a_onehot_vic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> $onehot0(r_victim)) else $error("victim not one-hot");
    a_onehot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> $onehot0(r_match)) else $error("duplicate key");
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OCC_W'($countones(r_valid))) else $error("occupancy mismatch");
endmodule

>>> hdl/lfu_cache_with_lru_tiebreak_unit.sv
// LFU cache, 16 entries, LRU tiebreak. Key match and victim search are
// registered at load, then the update registers the result, which is held
// until taken. One word in flight: the controller accepts only while idle.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
// Depends on lfuc_pkg, lfuc_if, lfuc_ctrl, lfuc_dp.
module lfu_cache_with_lru_tiebreak_unit import lfuc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lfuc_if.sink   in_ch,
    lfuc_if.sink   cfg_ch,
    lfuc_if.source out_ch
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign cfg_ch.ready = 1'b1;

    lfuc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_cmd(w_cmd)
    );

    lfuc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_ch.valid),
        .i_cfg_capacity(cfg_ch.payload),
        .i_cmd(w_cmd),
        .i_in_cmd(in_ch.payload.cmd),
        .i_in_key(in_ch.payload.key),
        .i_in_value(in_ch.payload.value),
        .o_status(w_status),
        .o_hit(out_ch.payload.hit),
        .o_read_value(out_ch.payload.read_value),
        .o_evicted(out_ch.payload.evicted),
        .o_evicted_key(out_ch.payload.evicted_key)
    );

    a_put_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_cmd.update) && w_status.is_put |-> out_ch.payload.read_value == '1)
        else $error("put returned data");
    a_dis_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_cmd.update) && !$past(w_status.enabled) |-> !out_ch.payload.hit)
        else $error("hit while disabled");
    a_get_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_cmd.update) && !w_status.is_put |-> !out_ch.payload.evicted)
        else $error("get evicted");
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LFU cache: random get/put traffic with
// capacity changes, checked against an in-bench LFU/LRU cache predictor.
// Depends on lfuc_pkg, lfuc_if and lfu_cache_with_lru_tiebreak_unit.
module tb_top;
    import lfuc_pkg::*;

    typedef struct packed {
        logic                    cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

    typedef enum logic [1:0] {OP_ACCESS, OP_SET_CAP, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind         kind;
        t_req             req;
        logic [CAP_W-1:0] cap;
    } t_op;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    lfuc_if #(.t_payload(t_req))             in_ch  (i_clk);
    lfuc_if #(.t_payload(logic [CAP_W-1:0])) cfg_ch (i_clk);
    lfuc_if #(.t_payload(t_rsp))             out_ch (i_clk);

    lfu_cache_with_lru_tiebreak_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    // cache predictor state
    logic             pc_valid [MAX_ENTRIES];
    logic [KEY_W-1:0] pc_key   [MAX_ENTRIES];
    logic [VAL_W-1:0] pc_data  [MAX_ENTRIES];
    logic [CNT_W-1:0] pc_count [MAX_ENTRIES];
    logic [IDX_W-1:0] pc_rank  [MAX_ENTRIES];
    int               pc_occ;
    logic [CAP_W-1:0] pc_cap;

    t_op  pending_ops[$];
    t_rsp expected_rsps[$];
    int   n_errors;
    int   n_words_in;
    int   n_words_out;
    int   n_hits;
    int   n_evicts;
    int   n_cap_writes;
    int   calm_from;
    bit   calm;

    function automatic void touch_entry(int s);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (pc_valid[i] && i != s && pc_rank[i] < pc_rank[s])
                pc_rank[i]++;
        pc_rank[s] = '0;
        if (pc_count[s] != '1)
            pc_count[s]++;
    endfunction

    function automatic t_rsp lfu_access(t_req r);
        t_rsp rsp;
        int   cap_eff;
        int   slot;
        int   victim;
        bit   found;
        bit   free_found;
        cap_eff = (pc_cap > MAX_ENTRIES) ? MAX_ENTRIES : pc_cap;
        rsp = '{hit: 1'b0, read_value: -1, evicted: 1'b0, evicted_key: '0};
        found = 0;
        free_found = 0;
        slot = 0;
        victim = -1;
        if (cap_eff == 0)
            return rsp;
        for (int i = 0; i < MAX_ENTRIES && !found; i++)
            if (pc_valid[i] && pc_key[i] == r.key) begin
                slot = i;
                found = 1;
            end
        if (found) begin
            rsp.hit = 1'b1;
            touch_entry(slot);
            if (r.cmd == CMD_GET)
                rsp.read_value = pc_data[slot];
            else
                pc_data[slot] = r.value;
        end else if (r.cmd == CMD_PUT) begin
            for (int i = 0; i < MAX_ENTRIES && !free_found; i++)
                if (!pc_valid[i]) begin
                    slot = i;
                    free_found = 1;
                end
            if (pc_occ >= cap_eff || !free_found) begin
                // lowest count wins, oldest among equals
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!pc_valid[i])
                        continue;
                    if (victim < 0 || pc_count[i] < pc_count[victim] ||
                        (pc_count[i] == pc_count[victim] && pc_rank[i] > pc_rank[victim]))
                        victim = i;
                end
                if (victim >= 0) begin
                    rsp.evicted = 1'b1;
                    rsp.evicted_key = pc_key[victim];
                    pc_valid[victim] = 1'b0;
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (pc_valid[i] && pc_rank[i] > pc_rank[victim])
                            pc_rank[i]--;
                    if (pc_occ != 0)
                        pc_occ--;
                    slot = victim;
                    free_found = 1;
                end
            end
            if (free_found) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (pc_valid[i])
                        pc_rank[i]++;
                pc_valid[slot] = 1'b1;
                pc_key[slot]   = r.key;
                pc_data[slot]  = r.value;
                pc_count[slot] = 1;
                pc_rank[slot]  = '0;
                pc_occ++;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on result %0d: %s expected %h got %h",
                 $realtime, n_words_out, field, want, got);
        n_errors++;
    endtask

    task automatic add_access(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_op op;
        op.kind = OP_ACCESS;
        op.req = '{cmd: cmd, key: key, value: value};
        op.cap = '0;
        pending_ops.push_back(op);
    endtask

    task automatic add_cap(logic [CAP_W-1:0] cap);
        t_op op;
        op.kind = OP_SET_CAP;
        op.req = '0;
        op.cap = cap;
        pending_ops.push_back(op);
    endtask

    task automatic add_drain();
        t_op op;
        op.kind = OP_DRAIN;
        op.req = '0;
        op.cap = '0;
        pending_ops.push_back(op);
    endtask

    // driver: request and capacity channels
    int gap_left;
    int settle;

    always @(posedge i_clk) begin
        logic nv;
        logic nc;
        t_op  op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            cfg_ch.valid <= 1'b0;
            gap_left = 0;
            settle = 0;
            pc_cap = 16;
            pc_occ = 0;
            for (int i = 0; i < MAX_ENTRIES; i++)
                pc_valid[i] = 1'b0;
        end else begin
            nv = in_ch.valid;
            nc = cfg_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                expected_rsps.push_back(lfu_access(in_ch.payload));
                n_words_in++;
                nv = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                pc_cap = cfg_ch.payload;
                n_cap_writes++;
                nc = 1'b0;
            end
            calm = n_words_in >= calm_from;
            if (expected_rsps.size() != 0 || nv || nc)
                settle = 0;
            else if (settle < SETTLE_CYCLES)
                settle++;
            if (!nv && !nc && pending_ops.size() != 0) begin
                op = pending_ops[0];
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op.kind == OP_ACCESS) begin
                    in_ch.payload <= op.req;
                    nv = 1'b1;
                    void'(pending_ops.pop_front());
                    if (!calm && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 9);
                end else if (settle >= SETTLE_CYCLES) begin
                    // block is idle: safe to change capacity
                    if (op.kind == OP_SET_CAP) begin
                        cfg_ch.payload <= op.cap;
                        nc = 1'b1;
                    end
                    void'(pending_ops.pop_front());
                end
            end
            in_ch.valid <= nv;
            cfg_ch.valid <= nc;
        end
    end

    // monitor: result channel with random backpressure
    int stall_left;

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                n_words_out++;
                if (expected_rsps.size() == 0) begin
                    $display("[%0t] result word with no access pending", $realtime);
                    n_errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    n_hits += want.hit;
                    n_evicts += want.evicted;
                    if (got.hit !== want.hit)
                        report_mismatch("hit", want.hit, got.hit);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, got.read_value);
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", want.evicted, got.evicted);
                    if (got.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool[$];
        int               caps[10];
        int               pool_n;
        logic [KEY_W-1:0] k;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready = 1'b0;
        n_errors = 0;
        n_words_in = 0;
        n_words_out = 0;
        n_hits = 0;
        n_evicts = 0;
        n_cap_writes = 0;
        calm_from = 32'h7fffffff;
        calm = 0;

        // directed: extreme keys/values, hit, miss, update, then capacity corners
        add_access(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        add_access(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        add_access(CMD_PUT, 32'h0000_0000, 32'hffff_ffff);
        add_access(CMD_PUT, 32'hffff_ffff, 32'h0000_0000);
        add_access(CMD_GET, 32'h8000_0000, 32'h1234_5678);
        add_access(CMD_GET, 32'hffff_ffff, 32'h0);
        add_access(CMD_GET, 32'h0000_0001, 32'h0);
        add_access(CMD_PUT, 32'h7fff_ffff, 32'h5a5a_a5a5);
        add_access(CMD_GET, 32'h7fff_ffff, 32'h0);
        add_cap(2);        // lowered below occupancy: no flush
        add_access(CMD_PUT, 32'h0000_0010, 32'h11);
        add_access(CMD_PUT, 32'h0000_0020, 32'h22);
        add_access(CMD_GET, 32'h0000_0020, 32'h0);
        add_access(CMD_PUT, 32'h0000_0030, 32'h33);
        add_cap(0);        // disabled: all miss, entries hidden
        add_access(CMD_GET, 32'h0000_0020, 32'h0);
        add_access(CMD_PUT, 32'h0000_0040, 32'h44);
        add_cap(31);       // above the slot count
        add_access(CMD_GET, 32'h0000_0020, 32'h0);
        add_access(CMD_GET, 32'h0000_0040, 32'h0);
        add_cap(1);
        add_access(CMD_PUT, 32'h0000_0050, 32'h55);
        add_access(CMD_PUT, 32'h0000_0060, 32'h66);
        add_access(CMD_GET, 32'h0000_0060, 32'h0);

        caps = '{16, 3, 31, 0, 1, 8, 17, 5, 2, 16};
        foreach (caps[p]) begin
            add_cap(CAP_W'(caps[p]));
            key_pool.delete();
            pool_n = (caps[p] > 16 ? 16 : caps[p]) + 3;
            for (int i = 0; i < pool_n; i++)
                key_pool.push_back($urandom);
            for (int i = 0; i < 108; i++) begin
                if (p == 4 && i == 50)
                    add_drain();
                if ($urandom_range(0, 9) < 9)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    k = $urandom;
                add_access(1'($urandom_range(0, 1)), k, $urandom);
            end
        end
        calm_from = 23 + 10 * 108 - 150;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_ch.valid || cfg_ch.valid ||
               expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            $display("%0d expected results never arrived", expected_rsps.size());
            n_errors++;
        end
        $display("ran %0d accesses, %0d capacity writes; %0d hits, %0d evictions",
                 n_words_in, n_cap_writes, n_hits, n_evicts);
        $display("%0d results checked, %0d mismatches", n_words_out, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
